FILE: design/assert_macros.svh
// assertion macros shared by the design files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define CHK_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled while reset is high
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: design/sitda_pkg.sv
// package for the signed integer to decimal ascii core
// types, constants and command/status structs shared by controller and datapath
package sitda_pkg;

   localparam int unsigned ValueWidth = 32;
   localparam int unsigned MaxDigits  = 10;
   localparam int unsigned DigitIdxW  = 4;

   localparam logic [7:0] AsciiZero  = 8'd48;
   localparam logic [7:0] AsciiMinus = 8'd45;

   // reciprocal of ten for a 32-bit dividend: q = (x * Recip10) >> Recip10Shift
   localparam logic [31:0] Recip10      = 32'hCCCC_CCCD;
   localparam int unsigned Recip10Shift = 35;

   localparam logic [DigitIdxW-1:0] LastDigitIdx = DigitIdxW'(MaxDigits - 1);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_CONVERT = 4'b0010,
      ST_SIGN    = 4'b0100,
      ST_DIGIT   = 4'b1000
   } state_type;

   typedef struct packed {
      logic load;
      logic divide;
      logic emit_next;
      logic sel_sign;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic negative;
      logic idx_zero;
   } status_type;

endpackage

FILE: design/sitda_datapath.sv
// datapath: magnitude register, divide-by-ten step, digit buffer, output select
// depends on sitda_pkg and assert_macros.svh
`include "assert_macros.svh"

module sitda_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic signed [sitda_pkg::ValueWidth-1:0] req_value,
   input  sitda_pkg::cmd_type                    cmd,
   output sitda_pkg::status_type                 status,
   output logic [7:0]                            rsp_char_code,
   output logic                                  rsp_is_last
);
   import sitda_pkg::*;

   logic [ValueWidth-1:0] mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [DigitIdxW-1:0]  ndig_ff, ndig_in;
   logic [DigitIdxW-1:0]  rd_idx_ff, rd_idx_in;
   logic [3:0]            digits_ff [MaxDigits];

   logic [2*ValueWidth-1:0] prod;
   logic [ValueWidth-1:0]   quot;
   logic [ValueWidth-1:0]   quot_x10;
   logic [ValueWidth-1:0]   rem_full;
   logic [3:0]              rem;

   always_comb begin
      prod     = (2*ValueWidth)'(mag_ff) * (2*ValueWidth)'(Recip10);
      quot     = ValueWidth'(prod >> Recip10Shift);
      quot_x10 = (quot << 3) + (quot << 1);
      rem_full = mag_ff - quot_x10;
      rem      = rem_full[3:0];
   end

   always_comb begin
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      ndig_in   = ndig_ff;
      rd_idx_in = rd_idx_ff;
      if (cmd.load) begin
         neg_in  = req_value[ValueWidth-1];
         // unsigned negation keeps the most negative value exact
         mag_in  = req_value[ValueWidth-1] ? (ValueWidth'(0) - ValueWidth'(req_value))
                                           : ValueWidth'(req_value);
         ndig_in = '0;
      end else if (cmd.divide) begin
         mag_in    = quot;
         ndig_in   = ndig_ff + DigitIdxW'(1);
         rd_idx_in = ndig_ff;
      end else if (cmd.emit_next) begin
         rd_idx_in = rd_idx_ff - DigitIdxW'(1);
      end
   end

   always_ff @(posedge clock) begin
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      ndig_ff   <= ndig_in;
      rd_idx_ff <= rd_idx_in;
      if (cmd.divide) begin
         digits_ff[ndig_ff] <= rem;
      end
   end

   always_comb begin
      status.div_done = (quot == '0) || (ndig_ff == LastDigitIdx);
      status.negative = neg_ff;
      status.idx_zero = (rd_idx_ff == '0);
   end

   always_comb begin
      if (cmd.sel_sign) begin
         rsp_char_code = AsciiMinus;
         rsp_is_last   = 1'b0;
      end else begin
         rsp_char_code = AsciiZero + {4'b0000, digits_ff[rd_idx_ff]};
         rsp_is_last   = (rd_idx_ff == '0);
      end
   end

   `CHK_SAME(a_div_in_range, clock, reset, cmd.divide, ndig_ff <= LastDigitIdx)
   `CHK_SAME(a_emit_not_past_first, clock, reset, cmd.emit_next, rd_idx_ff != '0)
   `CHK_NEXT(a_load_clears_count, clock, reset, cmd.load, ndig_ff == '0)

endmodule

FILE: design/sitda_ctrl.sv
// controller: sequences load, divide steps and character beats
// depends on sitda_pkg and assert_macros.svh
`include "assert_macros.svh"

module sitda_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  sitda_pkg::status_type status,
   output sitda_pkg::cmd_type    cmd
);
   import sitda_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.divide = 1'b1;
            if (status.div_done) begin
               state_in = status.negative ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            rsp_valid    = 1'b1;
            cmd.sel_sign = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (status.idx_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.emit_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // final digit beat taken ends the item
   `CHK_NEXT(a_last_beat_to_idle, clock, reset,
      rsp_valid && !rsp_stall && !cmd.sel_sign && status.idx_zero, state_ff == ST_IDLE)
   `CHK_NEXT(a_accept_starts_convert, clock, reset,
      req_valid && !req_stall, state_ff == ST_CONVERT)
   `CHK_SAME(a_no_accept_while_busy, clock, reset, rsp_valid, req_stall)

endmodule

FILE: design/signed_int_to_decimal_ascii_core.sv
// signed 32-bit integer to decimal ascii, one character per beat, last marked
// after acceptance the controller runs the single divide-by-ten step, one digit per cycle,
// then offers the minus sign if negative and the digits msd first, one beat per cycle unless
// rsp_stall holds it; a new integer is not accepted until the last character is taken
// reset: synchronous active-high reset returns the controller to idle, no item in flight
module signed_int_to_decimal_ascii_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [sitda_pkg::ValueWidth-1:0] req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [7:0]                            rsp_char_code,
   output logic                                  rsp_is_last
);
   import sitda_pkg::*;

   cmd_type    cmd;
   status_type status;

   sitda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sitda_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .cmd           (cmd),
      .status        (status),
      .rsp_char_code (rsp_char_code),
      .rsp_is_last   (rsp_is_last)
   );

endmodule

FILE: dv/tb_top.sv
// testbench for signed_int_to_decimal_ascii_core: directed and random integers in,
// decimal characters checked beat by beat against a local prediction
// depends on design/sitda_pkg.sv and the core rtl
module tb_top;

   import sitda_pkg::*;

   localparam int unsigned CycleLimit = 600000;
   localparam int unsigned QuietItems = 60;
   localparam int unsigned HoldCycles = 250;
   localparam int unsigned HoldAfter  = 60;
   localparam int unsigned DrainWait  = 40;

   typedef struct {
      logic [7:0] code;
      logic       last;
   } text_char_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic signed [31:0]    req_value;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [7:0]            rsp_char_code;
   logic                  rsp_is_last;

   logic [31:0]    pending_values [$];
   text_char_type  expected_chars [$];

   int unsigned n_launched;
   int unsigned n_accepted;
   int unsigned n_errors;
   int unsigned cycle_count;
   int unsigned req_gap;
   int unsigned stall_left;
   int unsigned hold_left;
   bit          hold_done;
   bit          stim_ready;

   signed_int_to_decimal_ascii_core i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_is_last   (rsp_is_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // expected text of one integer: optional minus, then digits msd first
   function automatic void predict_text(input logic [31:0] raw);
      logic [31:0]    mag;
      logic [7:0]     digit_codes [$];
      text_char_type  ch;
      mag = raw[31] ? (32'd0 - raw) : raw;
      do begin
         digit_codes.push_front(AsciiZero + 8'(mag % 32'd10));
         mag = mag / 32'd10;
      end while (mag != 0);
      if (raw[31]) begin
         ch.code = AsciiMinus;
         ch.last = 1'b0;
         expected_chars.push_back(ch);
      end
      for (int i = 0; i < digit_codes.size(); i++) begin
         ch.code = digit_codes[i];
         ch.last = (i == digit_codes.size() - 1);
         expected_chars.push_back(ch);
      end
   endfunction

   // random integer: fully random, small, of a chosen digit count and sign, or near a power of ten
   function automatic logic [31:0] random_value();
      longint lo;
      longint hi;
      longint mag;
      bit     neg;
      int     ndig;
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: begin
            mag = $urandom_range(0, 20);
            neg = $urandom_range(0, 1);
         end
         2: begin
            ndig = $urandom_range(1, 10);
            lo = 1;
            for (int i = 1; i < ndig; i++) lo = lo * 10;
            hi = lo * 10 - 1;
            if (ndig == 1) lo = 0;
            if (hi > 64'd2147483648) hi = 64'd2147483648;
            mag = lo + (longint'($urandom) % (hi - lo + 1));
            neg = $urandom_range(0, 1);
         end
         default: begin
            // around powers of ten
            ndig = $urandom_range(0, 9);
            mag = 1;
            for (int i = 0; i < ndig; i++) mag = mag * 10;
            mag = mag + $urandom_range(0, 2) - 1;
            neg = $urandom_range(0, 1);
         end
      endcase
      if (!neg && mag > 64'd2147483647) mag = 64'd2147483647;
      return neg ? 32'(-mag) : 32'(mag);
   endfunction

   // driver: next value or idle burst once the current beat is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_value <= '0;
         req_gap = 0;
      end else if (!req_valid || n_accepted == n_launched) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_values.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pending_values.size() > QuietItems && $urandom_range(0, 7) == 0) begin
            req_gap = $urandom_range(1, 18) - 1;
            req_valid <= 1'b0;
         end else begin
            req_value <= pending_values.pop_front();
            req_valid <= 1'b1;
            n_launched++;
         end
      end
   end

   // receiver: random stall bursts, one long hold-off while the sender keeps going, no stalls once few values remain
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_left = 0;
         hold_done = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && n_accepted >= HoldAfter) begin
         hold_done = 1'b1;
         hold_left = HoldCycles - 1;
         rsp_stall <= 1'b1;
      end else if (stim_ready && pending_values.size() < QuietItems) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 18) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: predict on each accepted integer, check each character beat
   always @(posedge clock) begin
      text_char_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_text(req_value);
            n_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected character beat, got code %0d last %0b",
                        $time, rsp_char_code, rsp_is_last);
               n_errors++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_char_code !== want.code) begin
                  $display("%0t: char_code expected %0d got %0d",
                           $time, want.code, rsp_char_code);
                  n_errors++;
               end
               if (rsp_is_last !== want.last) begin
                  $display("%0t: is_last expected %0b got %0b",
                           $time, want.last, rsp_is_last);
                  n_errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("signed_int_to_decimal_ascii_core: mismatch");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      rsp_stall = 1'b0;
      n_launched = 0;
      n_accepted = 0;
      n_errors = 0;
      cycle_count = 0;
      stim_ready = 1'b0;

      // extremes, zero, single digits, digit-count boundaries and mixed-digit patterns
      pending_values.push_back(32'sd0);
      pending_values.push_back(32'sd1);
      pending_values.push_back(-32'sd1);
      pending_values.push_back(32'sd9);
      pending_values.push_back(-32'sd9);
      pending_values.push_back(32'sd10);
      pending_values.push_back(-32'sd10);
      pending_values.push_back(32'sd99);
      pending_values.push_back(32'sd100);
      pending_values.push_back(32'sd999999999);
      pending_values.push_back(32'sd1000000000);
      pending_values.push_back(-32'sd1000000000);
      pending_values.push_back(32'sd2147483647);
      pending_values.push_back(32'h8000_0000);
      pending_values.push_back(32'h8000_0001);
      pending_values.push_back(32'sd123456789);
      pending_values.push_back(-32'sd987654321);
      pending_values.push_back(32'h5555_5555);
      pending_values.push_back(32'hAAAA_AAAA);
      pending_values.push_back(32'sd1999999999);
      for (int i = 0; i < 400; i++) pending_values.push_back(random_value());
      stim_ready = 1'b1;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_values.size() != 0 || n_accepted != n_launched) @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);

      if (expected_chars.size() != 0) begin
         $display("%0t: %0d expected characters never arrived", $time,
                  expected_chars.size());
         n_errors++;
      end
      if (n_errors == 0) begin
         $display("signed_int_to_decimal_ascii_core: match");
      end else begin
         $display("signed_int_to_decimal_ascii_core: mismatch");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+design
design/sitda_pkg.sv
design/sitda_datapath.sv
design/sitda_ctrl.sv
design/signed_int_to_decimal_ascii_core.sv
dv/tb_top.sv
